FILE: hw/rtl/vec3_fixed_point_alu_top_macros.svh
// Assertion macros for the vector ALU.
// Depends on nothing; included by the top level.
`ifndef VEC3_FIXED_POINT_ALU_TOP_MACROS_SVH
`define VEC3_FIXED_POINT_ALU_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define VA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("vec3 alu check");
`define VA_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vec3 alu reset check");
`else
`define VA_ASSERT(lbl, clk, rstn, prop)
`define VA_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/v3alu_pkg.sv
// Shared types and command codes for the vector ALU.
// Depends on nothing.
package v3alu_pkg;
  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;

  typedef enum logic [3:0] {
    CMD_ADD_V = 4'd0, CMD_SUB_V = 4'd1, CMD_MUL_V = 4'd2, CMD_DIV_V = 4'd3,
    CMD_ADD_S = 4'd4, CMD_SUB_S = 4'd5, CMD_MUL_S = 4'd6, CMD_DIV_S = 4'd7,
    CMD_MAG = 4'd8, CMD_DIST = 4'd9, CMD_NORM = 4'd10, CMD_DOT = 4'd11,
    CMD_CROSS = 4'd12
  } cmd_e;

  typedef struct packed {
    logic [3:0]            command;
    logic signed [DW-1:0]  a_x;
    logic signed [DW-1:0]  a_y;
    logic signed [DW-1:0]  a_z;
    logic signed [DW-1:0]  b_x;
    logic signed [DW-1:0]  b_y;
    logic signed [DW-1:0]  b_z;
    logic signed [DW-1:0]  scalar_b;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0]  res_x;
    logic signed [DW-1:0]  res_y;
    logic signed [DW-1:0]  res_z;
    logic signed [DW-1:0]  res_s;
    logic                  div_zero;
    logic                  overflow;
  } out_word_t;
endpackage

FILE: hw/rtl/v3alu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; carries a sideband of width SW alongside.
module v3alu_sqrt #(
  parameter int unsigned IW = 66,
  parameter int unsigned SW = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IW-1:0]       rad_i,
  input  logic [SW-1:0]       side_i,
  output logic [(IW+1)/2-1:0] root_o,
  output logic [SW-1:0]       side_o
);
  localparam int unsigned RW = (IW + 1) / 2;
  localparam int unsigned PW = 2 * RW;
  localparam int unsigned NS = RW;

  logic [PW-1:0] rem_q  [NS+1];
  logic [PW-1:0] rad_q  [NS+1];
  logic [RW-1:0] root_q [NS+1];
  logic [SW-1:0] side_q [NS+1];

  always_comb begin
    rem_q[0]  = '0;
    rad_q[0]  = PW'(rad_i);
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [PW+1:0] rem_sh;
    logic [PW+1:0] trial;
    logic [PW-1:0] rem_d;
    logic [RW-1:0] root_d;
    logic [PW-1:0] rem_r;
    logic [PW-1:0] rad_r;
    logic [RW-1:0] root_r;
    logic [SW-1:0] side_r;
    always_comb begin
      rem_sh = {rem_q[s], rad_q[s][PW-1 -: 2]};
      trial  = (PW+2)'({root_q[s], 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = PW'(rem_sh - trial);
        root_d = {root_q[s][RW-2:0], 1'b1};
      end else begin
        rem_d  = PW'(rem_sh);
        root_d = {root_q[s][RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= rem_d;
        rad_r  <= {rad_q[s][PW-3:0], 2'b00};
        root_r <= root_d;
        side_r <= side_q[s];
      end
    end
    assign rem_q[s+1]  = rem_r;
    assign rad_q[s+1]  = rad_r;
    assign root_q[s+1] = root_r;
    assign side_q[s+1] = side_r;
  end

  assign root_o = root_q[NS];
  assign side_o = side_q[NS];
endmodule

FILE: hw/rtl/v3alu_div.sv
// Pipelined restoring signed divider, one quotient bit per stage, truncating.
// Depends on nothing; n is the wide dividend, d the divisor.
module v3alu_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DWD = 34
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [NW-1:0]  n_i,
  input  logic signed [DWD-1:0] d_i,
  output logic signed [NW:0]    q_o
);
  localparam int unsigned RW = DWD + 1;

  logic [NW-1:0]  nq_q  [NW+1];
  logic [RW-1:0]  rm_q  [NW+1];
  logic [DWD-1:0] dv_q  [NW+1];
  logic           neg_q [NW+1];

  always_comb begin
    nq_q[0]  = n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
    rm_q[0]  = '0;
    dv_q[0]  = d_i[DWD-1] ? DWD'(-d_i) : DWD'(d_i);
    neg_q[0] = n_i[NW-1] ^ d_i[DWD-1];
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [RW:0]    sh;
    logic [RW-1:0]  rm_d;
    logic           qb;
    logic [NW-1:0]  nq_r;
    logic [RW-1:0]  rm_r;
    logic [DWD-1:0] dv_r;
    logic           neg_r;
    always_comb begin
      sh = {rm_q[s], nq_q[s][NW-1]};
      qb = (sh >= {2'b00, dv_q[s]});
      rm_d = qb ? RW'(sh - {2'b00, dv_q[s]}) : RW'(sh);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_r  <= {nq_q[s][NW-2:0], qb};
        rm_r  <= rm_d;
        dv_r  <= dv_q[s];
        neg_r <= neg_q[s];
      end
    end
    assign nq_q[s+1]  = nq_r;
    assign rm_q[s+1]  = rm_r;
    assign dv_q[s+1]  = dv_r;
    assign neg_q[s+1] = neg_r;
  end

  assign q_o = neg_q[NW] ? -$signed({1'b0, nq_q[NW]}) : $signed({1'b0, nq_q[NW]});
endmodule

FILE: hw/rtl/v3alu_lane.sv
// One component lane: front stage (sum/diff/product) and divider.
// Depends on v3alu_pkg and v3alu_div. Divider input is picked per command.
module v3alu_lane #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [DATA_WIDTH-1:0]   a_i,
  input  logic signed [DATA_WIDTH-1:0]   o_i,
  input  logic [1:0]                     op_i,
  input  logic                           dsel_i,
  input  logic signed [DATA_WIDTH+1:0]   dnorm_i,
  input  logic signed [DATA_WIDTH-1:0]   anorm_i,
  output logic signed [DATA_WIDTH+1:0]   arith_o,
  output logic signed [2*DATA_WIDTH+FRAC_BITS:0] quot_o,
  output logic signed [2*DATA_WIDTH-1:0] prod_o
);
  import v3alu_pkg::*;
  localparam int unsigned NW = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned DD = DATA_WIDTH + 2;

  logic signed [NW-1:0] n_div;
  logic signed [DD-1:0] d_div;
  logic signed [2*DATA_WIDTH-1:0] prod_d;
  logic signed [DATA_WIDTH+1:0]   arith_d;

  always_comb begin
    prod_d = $signed({{DATA_WIDTH{a_i[DATA_WIDTH-1]}}, a_i})
           * $signed({{DATA_WIDTH{o_i[DATA_WIDTH-1]}}, o_i});
    case (op_i)
      2'd0:    arith_d = (DATA_WIDTH+2)'(a_i) + (DATA_WIDTH+2)'(o_i);
      default: arith_d = (DATA_WIDTH+2)'(a_i) - (DATA_WIDTH+2)'(o_i);
    endcase
    if (dsel_i) begin
      n_div = $signed({anorm_i, {FRAC_BITS{1'b0}}});
      d_div = dnorm_i;
    end else begin
      n_div = $signed({a_i, {FRAC_BITS{1'b0}}});
      d_div = DD'(o_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o  <= prod_d;
      arith_o <= arith_d;
    end
  end

  v3alu_div #(.NW(NW), .DWD(DD)) u_div (
    .clk_i, .en_i,
    .n_i(n_div), .d_i(d_div), .q_o(quot_o[NW:0])
  );
  assign quot_o[2*DATA_WIDTH+FRAC_BITS:NW+1] = {(DATA_WIDTH){quot_o[NW]}};
endmodule

FILE: hw/rtl/vec3_fixed_point_alu_top.sv
// Three-component Q16.16 vector ALU: add/sub/mul/div, mag, dist, norm, dot, cross.
// Input word: command, a, b, scalar; output word: four results and two flags.
// Channels use valid/stall; a word is taken when valid is high and stall low.
// The whole pipeline advances together whenever its last stage is empty or the
// receiver is not stalling, so one word enters per cycle back to back.
// The pipe is one square/sum stage, DATA_WIDTH+1 square root stages (one root
// bit each), DATA_WIDTH+FRAC_BITS divider stages (one quotient bit each) and
// one output register. Commands that need no root or quotient still ride the
// full pipe so words leave in order.
// The root unit feeds three divider lanes, one per component; then a
// merge stage picks the result by command and saturates.
// Reset clears every valid bit; payload registers are not reset.
// A stall on the output while it holds a valid word holds the entire pipe and raises stall on the input.
// Unknown commands give all-zero results and flags.
`include "vec3_fixed_point_alu_top_macros.svh"
module vec3_fixed_point_alu_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  v3alu_pkg::in_word_t   in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output v3alu_pkg::out_word_t  out_word_o
);
  import v3alu_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned SQW  = 2 * W + 2;           // sum of three squares
  localparam int unsigned RTW  = (SQW + 1) / 2;        // root width
  localparam int unsigned NW   = W + FRAC_BITS;
  localparam int unsigned DLAT = NW;                   // divider stages
  localparam int unsigned SLAT = RTW;                  // root stages
  localparam int unsigned PW   = 2 * W + 4;            // wide products / sums
  localparam int unsigned TOT  = 1 + SLAT + DLAT;      // stages before output reg
  localparam int unsigned CW   = 4;

  // carried state of each word besides lanes
  typedef struct packed {
    logic [CW-1:0]         cmd;
    logic signed [W-1:0]   a_x, a_y, a_z;
    logic signed [W-1:0]   o_x, o_y, o_z;
    logic                  big;
  } side_t;

  logic advance;
  logic [TOT-1:0] vld_q;
  logic out_vld_q;
  out_word_t out_q;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = !advance;

  // stage 0: operand select, squares for root
  logic signed [W-1:0] ax, ay, az, ox, oy, oz;
  logic signed [W+1:0] dx, dy, dz;
  logic [W+1:0]        mx, my, mz;
  logic [SQW-1:0]      sq_d;
  logic                big_d;
  logic [CW-1:0]       cmd_i;

  always_comb begin
    cmd_i = in_word_i.command;
    ax = in_word_i.a_x; ay = in_word_i.a_y; az = in_word_i.a_z;
    if (cmd_i >= CMD_ADD_S && cmd_i <= CMD_DIV_S) begin
      ox = in_word_i.scalar_b; oy = in_word_i.scalar_b; oz = in_word_i.scalar_b;
    end else begin
      ox = in_word_i.b_x; oy = in_word_i.b_y; oz = in_word_i.b_z;
    end
    if (cmd_i == CMD_DIST) begin
      dx = (W+2)'(ax) - (W+2)'(in_word_i.b_x);
      dy = (W+2)'(ay) - (W+2)'(in_word_i.b_y);
      dz = (W+2)'(az) - (W+2)'(in_word_i.b_z);
    end else begin
      dx = (W+2)'(ax); dy = (W+2)'(ay); dz = (W+2)'(az);
    end
    mx = dx[W+1] ? (W+2)'(-dx) : (W+2)'(dx);
    my = dy[W+1] ? (W+2)'(-dy) : (W+2)'(dy);
    mz = dz[W+1] ? (W+2)'(-dz) : (W+2)'(dz);
    // a difference of 2^(W-1) or more in magnitude pins the distance to max
    big_d = ((|mx[W+1:W-1]) || (|my[W+1:W-1]) || (|mz[W+1:W-1]))
            && (cmd_i == CMD_DIST);
  end

  // squares registered first, then summed into the root
  logic [2*W+1:0] sqx_q, sqy_q, sqz_q;
  side_t          s0_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      sqx_q <= (2*W+2)'(mx) * (2*W+2)'(mx);
      sqy_q <= (2*W+2)'(my) * (2*W+2)'(my);
      sqz_q <= (2*W+2)'(mz) * (2*W+2)'(mz);
      s0_q  <= '{cmd: cmd_i, a_x: ax, a_y: ay, a_z: az,
                 o_x: ox, o_y: oy, o_z: oz, big: big_d};
    end
  end
  assign sq_d = SQW'(sqx_q) + SQW'(sqy_q) + SQW'(sqz_q);

  logic [RTW-1:0] root;
  side_t          s1;
  v3alu_sqrt #(.IW(SQW), .SW($bits(side_t))) u_sqrt (
    .clk_i, .en_i(advance),
    .rad_i(sq_d), .side_i(s0_q), .root_o(root), .side_o(s1)
  );

  // lanes: front stage products/sums then divider on root output stage
  logic [1:0] op1;
  logic       dsel;
  logic signed [W+1:0] dnorm;
  assign op1   = s1.cmd[1:0];
  assign dsel  = (s1.cmd == CMD_NORM);
  assign dnorm = $signed((W+2)'(root));

  logic signed [W+1:0]            ar [3];
  logic signed [2*W+FRAC_BITS:0]  qt [3];
  logic signed [2*W-1:0]          pr [3];
  logic signed [W-1:0]            la [3];
  logic signed [W-1:0]            lo [3];
  assign la = '{s1.a_x, s1.a_y, s1.a_z};
  assign lo = '{s1.o_x, s1.o_y, s1.o_z};

  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3alu_lane #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i, .en_i(advance),
      .a_i(la[l]), .o_i(lo[l]), .op_i(op1), .dsel_i(dsel),
      .dnorm_i(dnorm), .anorm_i(la[l]),
      .arith_o(ar[l]), .quot_o(qt[l]), .prod_o(pr[l])
    );
  end

  // cross products need a second set of multipliers beside the lanes
  logic signed [2*W-1:0] cp_q [6];
  always_ff @(posedge clk_i) begin
    if (advance) begin
      cp_q[0] <= $signed({{W{s1.a_y[W-1]}}, s1.a_y}) * $signed({{W{s1.o_z[W-1]}}, s1.o_z});
      cp_q[1] <= $signed({{W{s1.a_z[W-1]}}, s1.a_z}) * $signed({{W{s1.o_y[W-1]}}, s1.o_y});
      cp_q[2] <= $signed({{W{s1.a_z[W-1]}}, s1.a_z}) * $signed({{W{s1.o_x[W-1]}}, s1.o_x});
      cp_q[3] <= $signed({{W{s1.a_x[W-1]}}, s1.a_x}) * $signed({{W{s1.o_z[W-1]}}, s1.o_z});
      cp_q[4] <= $signed({{W{s1.a_x[W-1]}}, s1.a_x}) * $signed({{W{s1.o_y[W-1]}}, s1.o_y});
      cp_q[5] <= $signed({{W{s1.a_y[W-1]}}, s1.a_y}) * $signed({{W{s1.o_x[W-1]}}, s1.o_x});
    end
  end

  // fold lane results once; hold them alongside the divider
  logic signed [PW-1:0] fr_d [3];
  logic signed [PW-1:0] fs_d;
  logic signed [PW-1:0] fp [3];
  logic signed [PW-1:0] fc [6];
  logic [RTW-1:0]       root2_q;
  side_t                s2_q;
  logic                 dzr_d [3];
  logic signed [PW-1:0] fr_q [3];
  logic signed [PW-1:0] fs_q;
  logic                 dzr_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) fp[i] = PW'(pr[i] >>> FRAC_BITS);
    for (int i = 0; i < 6; i++) fc[i] = PW'(cp_q[i] >>> FRAC_BITS);
    fs_d = '0;
    for (int i = 0; i < 3; i++) begin
      fr_d[i]  = '0;
      dzr_d[i] = 1'b0;
    end
    unique case (s2_q.cmd) inside
      CMD_ADD_V, CMD_SUB_V, CMD_ADD_S, CMD_SUB_S:
        for (int i = 0; i < 3; i++) fr_d[i] = PW'(ar[i]);
      CMD_MUL_V, CMD_MUL_S:
        for (int i = 0; i < 3; i++) fr_d[i] = fp[i];
      CMD_DIV_V, CMD_DIV_S: begin
        dzr_d[0] = (s2_q.o_x == '0);
        dzr_d[1] = (s2_q.o_y == '0);
        dzr_d[2] = (s2_q.o_z == '0);
      end
      CMD_NORM: for (int i = 0; i < 3; i++) dzr_d[i] = (root2_q == '0);
      CMD_MAG:  fs_d = PW'(root2_q);
      CMD_DIST: fs_d = s2_q.big ? PW'({1'b1, {(W-1){1'b0}}}) : PW'(root2_q);
      CMD_DOT:  fs_d = fp[0] + fp[1] + fp[2];
      CMD_CROSS: begin
        fr_d[0] = fc[0] - fc[1];
        fr_d[1] = fc[2] - fc[3];
        fr_d[2] = fc[4] - fc[5];
      end
      default: fs_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      root2_q <= root;
      s2_q    <= s1;
    end
  end

  // delay line for front results to meet divider output
  localparam int unsigned HD = DLAT - 1;
  logic signed [PW-1:0] hr_q [HD+1][3];
  logic signed [PW-1:0] hs_q [HD+1];
  logic                 hz_q [HD+1][3];
  logic [CW-1:0]        hc_q [HD+1];
  always_comb begin
    hr_q[0] = fr_d; hs_q[0] = fs_d; hz_q[0] = dzr_d; hc_q[0] = s2_q.cmd;
  end
  for (genvar s = 0; s < HD; s++) begin : g_hold
    always_ff @(posedge clk_i) begin
      if (advance) begin
        hr_q[s+1] <= hr_q[s];
        hs_q[s+1] <= hs_q[s];
        hz_q[s+1] <= hz_q[s];
        hc_q[s+1] <= hc_q[s];
      end
    end
  end
  assign fr_q = hr_q[HD];
  assign fs_q = hs_q[HD];
  assign dzr_q = hz_q[HD];

  // merge stage: choose quotient or held result, saturate, flag
  localparam logic signed [PW-1:0] MAXV = PW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);
  logic signed [PW-1:0] mv [3];
  logic signed [W-1:0]  rv [3];
  logic signed [W-1:0]  rs;
  logic                 ov, dzf;
  logic                 isdiv;
  logic signed [2*W+FRAC_BITS:0] qsel;
  always_comb begin
    isdiv = (hc_q[HD] == CMD_DIV_V || hc_q[HD] == CMD_DIV_S || hc_q[HD] == CMD_NORM);
    ov  = 1'b0;
    dzf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qsel = qt[i];
      if (isdiv) begin
        if (dzr_q[i]) mv[i] = '0;
        else if (qsel > (2*W+FRAC_BITS+1)'(MAXV)) mv[i] = MAXV + PW'(1);
        else if (qsel < (2*W+FRAC_BITS+1)'(MINV)) mv[i] = MINV - PW'(1);
        else mv[i] = PW'(qsel);
      end else begin
        mv[i] = fr_q[i];
      end
      dzf = dzf | dzr_q[i];
      if (mv[i] > MAXV) begin rv[i] = W'(MAXV); ov = 1'b1; end
      else if (mv[i] < MINV) begin rv[i] = W'(MINV); ov = 1'b1; end
      else rv[i] = W'(mv[i]);
    end
    if (fs_q > MAXV) begin rs = W'(MAXV); ov = 1'b1; end
    else if (fs_q < MINV) begin rs = W'(MINV); ov = 1'b1; end
    else rs = W'(fs_q);
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q     <= {vld_q[TOT-2:0], in_valid_i};
      out_vld_q <= vld_q[TOT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= '{res_x: rv[0], res_y: rv[1], res_z: rv[2], res_s: rs,
                 div_zero: dzf, overflow: ov};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  `VA_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
  `VA_ASSERT(a_in_stall, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)
  `VA_ASSERT_RST(a_rst_clear, clk_i, !rst_ni |=> !out_valid_o || rst_ni)
endmodule

FILE: bench/tb_vec3_fixed_point_alu_top.sv
// Self-checking bench for the three-component Q16.16 vector ALU.
// Holds its own predictor of every command; needs v3alu_pkg and the top level.
`timescale 1ns / 1ps
module tb_vec3_fixed_point_alu_top;
  import v3alu_pkg::*;

  // First code past the defined commands; 13..15 must give an all-zero word.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd13;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  // Drain time, with margin over the pipe depth.
  localparam int DRAIN_CYCLES = 150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        words_total = 0;
  int        words_sent = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        send_idle_pct = 12;
  int        recv_stall_pct = 49;
  int        cmd_hits[16];

  vec3_fixed_point_alu_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Clamp to the signed 32-bit range and note any saturation.
  function automatic longint clamp32(longint v, inout bit ov);
    if (v > S32_MAX) begin
      ov = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      ov = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // Exact product floored by FB (arithmetic shift rounds toward minus infinity).
  function automatic longint fx_product(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  // (n << FB) / d truncated toward zero; a zero divisor yields zero and a flag.
  function automatic longint fx_quotient(longint n, longint d, inout bit dz);
    if (d == 0) begin
      dz = 1'b1;
      return 0;
    end
    return (n * (64'sd1 <<< FB)) / d;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Sum of squares of raw components fits 64 unsigned bits for |v| <= 2^31.
  function automatic longint vec_length(longint x, longint y, longint z);
    longint unsigned ux, uy, uz;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    uz = (z < 0) ? -z : z;
    return longint'(root_floor(ux * ux + uy * uy + uz * uz));
  endfunction

  function automatic out_word_t alu_result(in_word_t w);
    longint    a[3], b[3], r[3], d[3];
    longint    s, opnd, v, m;
    bit        dz, ov, big;
    out_word_t o;
    a[0] = w.a_x;  a[1] = w.a_y;  a[2] = w.a_z;
    b[0] = w.b_x;  b[1] = w.b_y;  b[2] = w.b_z;
    r = '{0, 0, 0};
    s = 0;
    dz = 1'b0;
    ov = 1'b0;
    case (w.command)
      CMD_ADD_V, CMD_SUB_V, CMD_MUL_V, CMD_DIV_V,
      CMD_ADD_S, CMD_SUB_S, CMD_MUL_S, CMD_DIV_S: begin
        for (int i = 0; i < 3; i++) begin
          opnd = (w.command >= CMD_ADD_S) ? longint'(w.scalar_b) : b[i];
          case (w.command)
            CMD_ADD_V, CMD_ADD_S: v = a[i] + opnd;
            CMD_SUB_V, CMD_SUB_S: v = a[i] - opnd;
            CMD_MUL_V, CMD_MUL_S: v = fx_product(a[i], opnd);
            default:              v = fx_quotient(a[i], opnd, dz);
          endcase
          r[i] = clamp32(v, ov);
        end
      end
      CMD_MAG: s = clamp32(vec_length(a[0], a[1], a[2]), ov);
      CMD_DIST: begin
        big = 1'b0;
        for (int i = 0; i < 3; i++) begin
          d[i] = a[i] - b[i];
          if (d[i] >= 64'sd2147483648 || d[i] <= -64'sd2147483648) big = 1'b1;
        end
        if (big) s = clamp32(64'sd2147483648, ov);
        else     s = clamp32(vec_length(d[0], d[1], d[2]), ov);
      end
      CMD_NORM: begin
        // Divide by the unsaturated length.
        m = vec_length(a[0], a[1], a[2]);
        for (int i = 0; i < 3; i++) r[i] = clamp32(fx_quotient(a[i], m, dz), ov);
      end
      CMD_DOT: begin
        s = clamp32(fx_product(a[0], b[0]) + fx_product(a[1], b[1])
                    + fx_product(a[2], b[2]), ov);
      end
      CMD_CROSS: begin
        r[0] = clamp32(fx_product(a[1], b[2]) - fx_product(a[2], b[1]), ov);
        r[1] = clamp32(fx_product(a[2], b[0]) - fx_product(a[0], b[2]), ov);
        r[2] = clamp32(fx_product(a[0], b[1]) - fx_product(a[1], b[0]), ov);
      end
      default: ;  // unused codes: everything stays zero
    endcase
    o.res_x    = r[0][31:0];
    o.res_y    = r[1][31:0];
    o.res_z    = r[2][31:0];
    o.res_s    = s[31:0];
    o.div_zero = dz;
    o.overflow = ov;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Mix of zeros, extremes, full-range and small values within +/-16.0 in Q16.16.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic in_word_t make_word(logic [3:0] cmd, logic [31:0] ax, logic [31:0] ay,
                                         logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                         logic [31:0] bz, logic [31:0] sc);
    in_word_t w;
    w.command = cmd;
    w.a_x = ax;  w.a_y = ay;  w.a_z = az;
    w.b_x = bx;  w.b_y = by;  w.b_z = bz;
    w.scalar_b = sc;
    return w;
  endfunction

  initial begin
    in_word_t   w;
    logic [3:0] cmd;
    // Directed: extremes per command, zero divisors, zero-vector normalize,
    // distance with an oversized difference, unused codes.
    pending_words.push_back(make_word(CMD_ADD_V, 32'h7fffffff, 32'h80000000, 32'h10000,
                                      32'h1, 32'hffffffff, 32'h10000, 0));
    pending_words.push_back(make_word(CMD_SUB_V, 32'h80000000, 32'h7fffffff, 0,
                                      32'h1, 32'hffffffff, 32'h80000000, 0));
    pending_words.push_back(make_word(CMD_MUL_V, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                                      32'h7fffffff, 32'h80000000, 32'h1, 0));
    pending_words.push_back(make_word(CMD_DIV_V, 32'h10000, 32'h7fffffff, 32'h80000000,
                                      0, 32'h1, 32'hffffffff, 0));
    pending_words.push_back(make_word(CMD_ADD_S, 32'h7fffffff, 32'h80000000, 32'h5,
                                      0, 0, 0, 32'h7fffffff));
    pending_words.push_back(make_word(CMD_SUB_S, 32'h80000000, 32'h7fffffff, 32'h5,
                                      0, 0, 0, 32'h80000000));
    pending_words.push_back(make_word(CMD_MUL_S, 32'h7fffffff, 32'hfffe0000, 32'h3,
                                      0, 0, 0, 32'hffff8000));
    pending_words.push_back(make_word(CMD_DIV_S, 32'h10000, 32'hffff0000, 0,
                                      0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DIV_S, 32'h7fffffff, 32'h80000000, 32'h30000,
                                      0, 0, 0, 32'hffffffff));
    pending_words.push_back(make_word(CMD_MAG, 32'h80000000, 32'h80000000, 32'h80000000,
                                      0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_MAG, 32'h30000, 32'h40000, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DIST, 32'h7fffffff, 0, 0,
                                      32'h80000000, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DIST, 32'h80000000, 0, 0, 32'h1, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DIST, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_NORM, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_NORM, 32'h1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_NORM, 32'h80000000, 32'h7fffffff, 32'h1, 0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    pending_words.push_back(make_word(CMD_DOT, 32'h80000000, 32'hffffffff, 32'h10000,
                                      32'h7fffffff, 32'h1, 32'hffff0000, 0));
    pending_words.push_back(make_word(CMD_CROSS, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                      32'h80000000, 32'h7fffffff, 32'h80000000, 0));
    pending_words.push_back(make_word(CMD_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0));
    pending_words.push_back(make_word(CMD_UNUSED_LO, 32'h7fffffff, 1, 2, 3, 4, 5, 6));
    pending_words.push_back(make_word(CMD_UNUSED_HI, 32'hffffffff, 32'hffffffff,
                                      32'hffffffff, 32'hffffffff, 32'hffffffff,
                                      32'hffffffff, 32'hffffffff));
    // Random part; mostly defined commands, a few unused codes.
    repeat (1400) begin
      if ($urandom_range(0, 19) == 0) cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else                            cmd = 4'($urandom_range(CMD_ADD_V, CMD_CROSS));
      w = make_word(cmd, pick_value(), pick_value(), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value());
      pending_words.push_back(w);
    end
    words_total = pending_words.size();
  end

  // ---------------------------------------------------------------------------
  // Driver: advance on acceptance, hold a stalled word, idle at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(alu_result(in_word_i));
        cmd_hits[in_word_i.command]++;
        words_sent++;
        // Switch idle profile by thirds of the run.
        if (words_sent == words_total / 3) begin
          send_idle_pct = 49;
          recv_stall_pct = 12;
        end else if (words_sent == 2 * words_total / 3) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      end
      if (in_valid_i && in_stall_o) begin
        // hold: payload must not change while stalled
      end else if (pending_words.size() != 0
                   && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word_i <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result word %h", $realtime, out_word_o);
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.res_x !== want.res_x || out_word_o.res_y !== want.res_y
              || out_word_o.res_z !== want.res_z || out_word_o.res_s !== want.res_s
              || out_word_o.div_zero !== want.div_zero
              || out_word_o.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d: exp x=%h y=%h z=%h s=%h dz=%b ov=%b",
                       $realtime, results_seen, want.res_x, want.res_y, want.res_z,
                       want.res_s, want.div_zero, want.overflow);
              $display("[%0t] result %0d: got x=%h y=%h z=%h s=%h dz=%b ov=%b",
                       $realtime, results_seen, out_word_o.res_x, out_word_o.res_y,
                       out_word_o.res_z, out_word_o.res_s, out_word_o.div_zero,
                       out_word_o.overflow);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (words_total != 0 && words_sent == words_total && expected_words.size() == 0);
    // Let the pipe drain to catch any stray extra word.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += expected_words.size();
    $display("Sent %0d words over all 13 commands plus unused codes, %0d results checked",
             words_sent, results_seen);
    $display("Idle profiles: sender-light/receiver-heavy, reversed, then back to back");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Generous bound: ~1.4k words under heavy stalls plus the pipe depth.
  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: vec3_fixed_point_alu_top.f
+incdir+hw/rtl
hw/rtl/v3alu_pkg.sv
hw/rtl/v3alu_sqrt.sv
hw/rtl/v3alu_div.sv
hw/rtl/v3alu_lane.sv
hw/rtl/vec3_fixed_point_alu_top.sv
bench/tb_vec3_fixed_point_alu_top.sv
